// File: rtl/open_addressing_hash_table_defines.svh
// Assertion macros for the open-addressing hash table.
// Used by the RTL file that carries concurrent checks (the top level).
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define OAHT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define OAHT_ASSERT(label, clk, rst_n, prop)
`define OAHT_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: rtl/oaht_pkg.sv
// Shared types and codes for the open-addressing hash table.
// No dependencies.
`default_nettype none
package oaht_pkg;
    typedef enum logic [1:0] {CMD_INSERT = 2'd0, CMD_SEARCH = 2'd1, CMD_DELETE = 2'd2,
                              CMD_NONE = 2'd3} cmd_t;
    typedef enum logic [1:0] {ST_DONE = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2,
                              ST_RSVD = 2'd3} status_t;
    typedef enum logic [2:0] {REG_MODE = 3'd0, REG_LIN = 3'd1, REG_SQ = 3'd2,
                              REG_SIZE = 3'd3, REG_PRIME = 3'd4} reg_idx_t;
    typedef enum logic [3:0] {S_IDLE, S_KMOD, S_SETUP, S_ADDR, S_READ, S_CHECK,
                              S_NEXT, S_WRITE, S_OUT} fsm_t;
    localparam int CFG_W = 11;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W = 10;
endpackage
`default_nettype wire

// File: rtl/oaht_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface oaht_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/oaht_modred.sv
// Bit-serial remainder unit: a mod b, one quotient bit a cycle.
// Depends on nothing.
`default_nettype none
module oaht_modred #(
    parameter int AW = 32,
    parameter int BW = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic               done,
    output logic [BW-1:0]      rem
);
    localparam int CW = $clog2(AW + 1);
    logic [AW-1:0] a_reg;
    logic [BW:0]   r_reg;
    logic [BW-1:0] b_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [BW:0]   shifted;
    logic [BW:0]   diff;

    always_comb
    begin
        shifted = {r_reg[BW-1:0], a_reg[AW-1]};
        diff    = shifted - {1'b0, b_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(AW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // restoring step; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg <= {a_reg[AW-2:0], 1'b0};
            r_reg <= diff[BW] ? shifted : diff;
        end
    end
    assign rem = r_reg[BW-1:0];
endmodule
`default_nettype wire

// File: rtl/oaht_store.sv
// Slot memory: one synchronous port with registered read data.
// Depends on nothing.
`default_nettype none
module oaht_store #(
    parameter int DEPTH = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [KEY_BITS-1:0]      wdata,
    output logic      [KEY_BITS-1:0]      rdata
);
    logic [KEY_BITS-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/open_addressing_hash_table.sv
// Open-addressing hash table, top level: control FSM, probe arithmetic.
// Uses oaht_pkg, oaht_if, oaht_modred, oaht_store and the defines header.
//
// Usage: cfg_we/cfg_index/cfg_data write probe_mode, linear_coeff,
// square_coeff, table_size, step_prime (indexes 0..4) while idle.
// in_ch beats carry {command, key}; out_ch beats carry {status, slot}.
// One item at a time. Each item runs the bit-serial remainder unit three
// times (key mod m, then key mod R and step mod m, or the two coefficients
// mod m) for set-up. Each probe then steps through address, memory read,
// check and probe update by compare and subtract; a slot write adds a
// write step before the result. A zero key or the unused command goes
// straight to the result.
// After reset the slot memory is cleared by a sweep over every slot,
// during which in_ch is not ready; configuration is taken throughout.
// The result waits in the output register while out_ch stalls; in_ch is
// ready again once the result is taken.
`default_nettype none
`include "open_addressing_hash_table_defines.svh"
module open_addressing_hash_table #(
    parameter int DEPTH = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]  cfg_data,
    oaht_if.sink                             in_ch,
    oaht_if.source                           out_ch
);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = AW + 1;
    localparam int KW = 32;

    logic                  mode_reg;
    logic [9:0]            lin_reg, sq_reg, prime_reg;
    logic [10:0]           size_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0; lin_reg <= 10'd1; sq_reg <= 10'd1;
            size_reg <= 11'd1024; prime_reg <= 10'd1021;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                oaht_pkg::REG_MODE:  mode_reg  <= cfg_data[0];
                oaht_pkg::REG_LIN:   lin_reg   <= cfg_data[9:0];
                oaht_pkg::REG_SQ:    sq_reg    <= cfg_data[9:0];
                oaht_pkg::REG_SIZE:  size_reg  <= cfg_data;
                oaht_pkg::REG_PRIME: prime_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // effective modulus, clamped to 1..DEPTH
    logic [MW-1:0] m_eff;
    always_comb
    begin
        if (size_reg == 11'd0)
            m_eff = MW'(1);
        else if ({{(MW > 11 ? MW-11 : 0){1'b0}}, size_reg} > (MW > 11 ? MW : 11)'(DEPTH))
            m_eff = MW'(DEPTH);
        else
            m_eff = MW'(size_reg);
    end
    logic [10:0] r_eff;
    assign r_eff = (prime_reg == 10'd0) ? 11'd1 : {1'b0, prime_reg};

    // state
    oaht_pkg::fsm_t state_reg, state_next;
    logic [AW:0]          clr_reg;
    logic                 clearing;
    oaht_pkg::cmd_t       cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [MW-1:0]        m_reg, base_reg, i_reg, step_reg;
    logic [MW-1:0]        lin_acc_reg, sq_acc_reg, sqd_reg, j_reg;
    logic [MW-1:0]        lin_c_reg, sq_c_reg;
    logic [1:0]           status_reg;
    logic [AW-1:0]        slot_reg;
    logic                 out_valid_reg;
    logic [KEY_BITS-1:0]  rdata;
    logic                 hit;
    logic [10:0]          rprime_reg;

    assign clearing = !clr_reg[AW];

    // remainder unit: key mod m, key mod R, coefficients mod m, step mod m
    logic          mr_start, mr_done;
    logic [KW-1:0] mr_a;
    logic [10:0]   mr_b;
    logic [10:0]   mr_rem;
    logic [2:0]    phase_reg;
    oaht_modred #(.AW(KW), .BW(11)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mr_start), .a(mr_a), .b(mr_b),
        .done(mr_done), .rem(mr_rem)
    );

    logic [KW-1:0] key32;
    assign key32 = KW'(key_reg);

    always_comb
    begin
        unique case (phase_reg)
            3'd0:    begin mr_a = key32;                    mr_b = 11'(m_reg); end
            3'd1:    begin mr_a = key32;                    mr_b = r_eff;      end
            3'd2:    begin mr_a = KW'(lin_reg);             mr_b = 11'(m_reg); end
            3'd3:    begin mr_a = KW'(sq_reg);              mr_b = 11'(m_reg); end
            default: begin mr_a = KW'(r_eff - rprime_reg);  mr_b = 11'(m_reg); end
        endcase
    end

    // modular add of two values below m
    function automatic logic [MW-1:0] madd(input logic [MW-1:0] x, input logic [MW-1:0] y,
                                           input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MW-1:0];
    endfunction

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [KEY_BITS-1:0] mem_wdata;

    oaht_store #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_store (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(rdata)
    );

    assign hit = (cmd_reg == oaht_pkg::CMD_INSERT) ? (rdata == '0) : (rdata == key_reg);
    assign in_ch.ready = (state_reg == oaht_pkg::S_IDLE) && !clearing && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = {status_reg, oaht_pkg::SLOT_W'(slot_reg)};

    always_comb
    begin
        state_next = state_reg;
        mr_start   = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = j_reg[AW-1:0];
        mem_wdata  = (cmd_reg == oaht_pkg::CMD_INSERT) ? key_reg : '0;
        if (clearing)
        begin
            mem_we = 1'b1; mem_addr = clr_reg[AW-1:0]; mem_wdata = '0;
        end
        unique case (state_reg)
            oaht_pkg::S_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    if (KEY_BITS'(in_ch.data[KW-1:0]) == '0 ||
                        in_ch.data[KW+1:KW] == oaht_pkg::CMD_NONE)
                        state_next = oaht_pkg::S_OUT;
                    else
                        state_next = oaht_pkg::S_KMOD;
                end
            oaht_pkg::S_KMOD:
            begin
                mr_start = 1'b1; state_next = oaht_pkg::S_SETUP;
            end
            oaht_pkg::S_SETUP:
                if (mr_done)
                begin
                    if (phase_reg == 3'd4 || (phase_reg == 3'd3 && !mode_reg) ||
                        (phase_reg == 3'd1 && mode_reg))
                        state_next = (phase_reg == 3'd1) ? oaht_pkg::S_KMOD : oaht_pkg::S_ADDR;
                    else
                        state_next = oaht_pkg::S_KMOD;
                end
            oaht_pkg::S_ADDR:  state_next = oaht_pkg::S_READ;
            oaht_pkg::S_READ:  state_next = oaht_pkg::S_CHECK;
            oaht_pkg::S_CHECK:
                if (hit)
                    state_next = (cmd_reg == oaht_pkg::CMD_SEARCH) ? oaht_pkg::S_OUT
                                                                   : oaht_pkg::S_WRITE;
                else if (i_reg + 1'b1 >= m_reg)
                    state_next = oaht_pkg::S_OUT;
                else
                    state_next = oaht_pkg::S_NEXT;
            oaht_pkg::S_NEXT:  state_next = oaht_pkg::S_ADDR;
            oaht_pkg::S_WRITE:
            begin
                mem_we = 1'b1; state_next = oaht_pkg::S_OUT;
            end
            oaht_pkg::S_OUT:   state_next = oaht_pkg::S_IDLE;
            default:           state_next = oaht_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oaht_pkg::S_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == oaht_pkg::S_OUT)
                out_valid_reg <= 1'b1;
            if (state_reg == oaht_pkg::S_IDLE)
                phase_reg <= 3'd0;
            else if (state_reg == oaht_pkg::S_SETUP && mr_done)
            begin
                if (phase_reg == 3'd0)
                    phase_reg <= mode_reg ? 3'd1 : 3'd2;
                else if (phase_reg == 3'd1)
                    phase_reg <= 3'd4;
                else
                    phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    // datapath: capture, set-up, probe update, result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            oaht_pkg::S_IDLE:
                // result register holds while out_ch stalls
                if (in_ch.valid && in_ch.ready)
                begin
                    cmd_reg    <= oaht_pkg::cmd_t'(in_ch.data[KW+1:KW]);
                    key_reg    <= KEY_BITS'(in_ch.data[KW-1:0]);
                    m_reg      <= m_eff;
                    status_reg <= oaht_pkg::ST_NOT_FOUND;
                    slot_reg   <= '0;
                end
            oaht_pkg::S_SETUP:
                if (mr_done)
                begin
                    unique case (phase_reg)
                        3'd0: base_reg <= MW'(mr_rem);
                        3'd1: rprime_reg <= mr_rem;
                        3'd2: lin_c_reg <= MW'(mr_rem);
                        3'd3: sq_c_reg <= MW'(mr_rem);
                        default: step_reg <= MW'(mr_rem);
                    endcase
                    if (phase_reg == 3'd0)
                    begin
                        j_reg <= MW'(mr_rem);
                        i_reg <= '0;
                        lin_acc_reg <= '0;
                        sq_acc_reg <= '0;
                        sqd_reg <= '0;
                    end
                    if (phase_reg == 3'd3)
                        sqd_reg <= MW'(mr_rem);
                end
            oaht_pkg::S_CHECK:
            begin
                if (hit)
                begin
                    status_reg <= oaht_pkg::ST_DONE;
                    slot_reg   <= j_reg[AW-1:0];
                end
                else if (cmd_reg == oaht_pkg::CMD_INSERT)
                    status_reg <= oaht_pkg::ST_FULL;
            end
            oaht_pkg::S_NEXT:
            begin
                i_reg <= i_reg + 1'b1;
                if (mode_reg)
                    j_reg <= madd(j_reg, step_reg, m_reg);
                else
                begin
                    // sq term advances by sq*(2i+1); kept as running delta
                    j_reg <= madd(madd(base_reg, madd(lin_acc_reg, lin_c_reg, m_reg), m_reg),
                                  madd(sq_acc_reg, sqd_reg, m_reg), m_reg);
                    lin_acc_reg <= madd(lin_acc_reg, lin_c_reg, m_reg);
                    sq_acc_reg  <= madd(sq_acc_reg, sqd_reg, m_reg);
                    sqd_reg     <= madd(sqd_reg, madd(sq_c_reg, sq_c_reg, m_reg), m_reg);
                end
            end
            oaht_pkg::S_OUT:
                if (status_reg != oaht_pkg::ST_DONE)
                    slot_reg <= '0;
            default: ;
        endcase
    end

    // checks
    `OAHT_ASSERT(a_no_accept_clear, clk, rst_n, clearing |-> !in_ch.ready)
    `OAHT_ASSERT(a_out_slot_zero, clk, rst_n,
        (out_ch.valid && status_reg != oaht_pkg::ST_DONE) |-> (slot_reg == '0))
    `OAHT_ASSERT(a_write_in_range, clk, rst_n,
        (state_reg == oaht_pkg::S_WRITE) |-> (j_reg < m_reg))
    `OAHT_ASSERT(a_probe_bound, clk, rst_n,
        (state_reg == oaht_pkg::S_CHECK) |-> (i_reg < m_reg))
endmodule
`default_nettype wire
